// ===== design/sbct_pkg.sv =====
// sbct_pkg: shared types for the swept box contact time block
// lane numbering and the control word carried down the divider chain
`timescale 1ns / 1ps
`default_nettype none
package sbct_pkg;

    // lanes: 0 entry x, 1 exit x, 2 entry y, 3 exit y
    localparam int NUM_LANES = 4;

    typedef struct packed {
        logic                 early_hit;   // boxes overlap or touch at start
        logic                 miss;        // separated and never closing on some axis
        logic [NUM_LANES-1:0] en;          // lane sets an entry or exit limit
        logic [NUM_LANES-1:0] sat;         // lane quotient at or above two, clamp
    } ctl_t;

endpackage
`default_nettype wire

// ===== design/sbct_front.sv =====
// sbct_front: input register stage, builds gaps, speeds and flags per axis
// depends on sbct_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbct_front #(
    parameter int COORD_BITS     = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          in_valid,
    output logic                                               in_stall,
    input  wire logic signed [COORD_BITS-1:0]                  a_min_x,
    input  wire logic signed [COORD_BITS-1:0]                  a_min_y,
    input  wire logic signed [COORD_BITS-1:0]                  a_max_x,
    input  wire logic signed [COORD_BITS-1:0]                  a_max_y,
    input  wire logic signed [COORD_BITS-1:0]                  b_min_x,
    input  wire logic signed [COORD_BITS-1:0]                  b_min_y,
    input  wire logic signed [COORD_BITS-1:0]                  b_max_x,
    input  wire logic signed [COORD_BITS-1:0]                  b_max_y,
    input  wire logic signed [COORD_BITS-1:0]                  vel_a_x,
    input  wire logic signed [COORD_BITS-1:0]                  vel_a_y,
    input  wire logic signed [COORD_BITS-1:0]                  vel_b_x,
    input  wire logic signed [COORD_BITS-1:0]                  vel_b_y,
    input  wire logic                                          dn_ready,
    output logic                                               dn_valid,
    output sbct_pkg::ctl_t                                     dn_ctl,
    output logic [sbct_pkg::NUM_LANES-1:0][COORD_BITS:0]       dn_rem,
    output logic [1:0][COORD_BITS-1:0]                         dn_spd,
    output logic [sbct_pkg::NUM_LANES-1:0][TIME_FRAC_BITS:0]   dn_q
);
    localparam int RW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] amin [2];
    logic signed [COORD_BITS-1:0] amax [2];
    logic signed [COORD_BITS-1:0] bmin [2];
    logic signed [COORD_BITS-1:0] bmax [2];
    logic signed [COORD_BITS-1:0] va   [2];
    logic signed [COORD_BITS-1:0] vb   [2];
    logic signed [RW-1:0]         vrel [2];
    logic signed [RW-1:0]         vneg [2];
    logic [1:0]                   sep;
    logic [1:0]                   axis_miss;

    logic                                     valid_reg, valid_next;
    logic                                     up_ready;
    sbct_pkg::ctl_t                           ctl_reg, ctl_next;
    logic [sbct_pkg::NUM_LANES-1:0][RW-1:0]   rem_reg, rem_next;
    logic [1:0][COORD_BITS-1:0]               spd_reg, spd_next;

    assign amin[0] = a_min_x;  assign amin[1] = a_min_y;
    assign amax[0] = a_max_x;  assign amax[1] = a_max_y;
    assign bmin[0] = b_min_x;  assign bmin[1] = b_min_y;
    assign bmax[0] = b_max_x;  assign bmax[1] = b_max_y;
    assign va[0]   = vel_a_x;  assign va[1]   = vel_a_y;
    assign vb[0]   = vel_b_x;  assign vb[1]   = vel_b_y;

    always_comb
    begin
        logic signed [RW-1:0] d_bmin_amax;
        logic signed [RW-1:0] d_bmax_amin;
        logic signed [RW-1:0] d_amin_bmax;
        logic signed [RW-1:0] d_amax_bmin;
        logic [RW-1:0]        gap_in;
        logic [RW-1:0]        gap_out;
        logic                 neg;
        logic                 zero;
        ctl_next = '0;
        rem_next = '0;
        spd_next = '0;
        for (int i = 0; i < 2; i++)
        begin
            vrel[i] = RW'(vb[i]) - RW'(va[i]);
            vneg[i] = -vrel[i];
            neg  = vrel[i][RW-1];
            zero = (vrel[i] == '0);
            sep[i] = (amax[i] < bmin[i]) || (bmax[i] < amin[i]);
            d_bmin_amax = RW'(bmin[i]) - RW'(amax[i]);
            d_bmax_amin = RW'(bmax[i]) - RW'(amin[i]);
            d_amin_bmax = RW'(amin[i]) - RW'(bmax[i]);
            d_amax_bmin = RW'(amax[i]) - RW'(bmin[i]);
            spd_next[i] = neg ? vneg[i][COORD_BITS-1:0] : vrel[i][COORD_BITS-1:0];
            gap_in  = neg ? d_bmin_amax : d_amin_bmax;
            gap_out = neg ? d_bmax_amin : d_amax_bmin;
            rem_next[2*i]   = gap_in;
            rem_next[2*i+1] = gap_out;
            if (neg)
            begin
                axis_miss[i]       = (bmax[i] < amin[i]);
                ctl_next.en[2*i]   = (amax[i] < bmin[i]);
                ctl_next.en[2*i+1] = (amin[i] < bmax[i]);
            end
            else if (zero)
            begin
                axis_miss[i]       = sep[i];
                ctl_next.en[2*i]   = 1'b0;
                ctl_next.en[2*i+1] = 1'b0;
            end
            else
            begin
                axis_miss[i]       = (bmin[i] > amax[i]);
                ctl_next.en[2*i]   = (amin[i] > bmax[i]);
                ctl_next.en[2*i+1] = (amax[i] > bmin[i]);
            end
            // quotient of two or more always clamps to one
            ctl_next.sat[2*i]   = (gap_in  >= {spd_next[i], 1'b0});
            ctl_next.sat[2*i+1] = (gap_out >= {spd_next[i], 1'b0});
        end
        ctl_next.early_hit = !sep[0] && !sep[1];
        ctl_next.miss      = axis_miss[0] || axis_miss[1];
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign in_stall   = !up_ready;
    assign valid_next = up_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && in_valid)
        begin
            ctl_reg <= ctl_next;
            rem_reg <= rem_next;
            spd_reg <= spd_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_spd   = spd_reg;
    assign dn_q     = '0;
endmodule
`default_nettype wire

// ===== design/sbct_cell.sv =====
// sbct_cell: one restoring division step on all four lanes, one quotient bit
// depends on sbct_pkg
`timescale 1ns / 1ps
`default_nettype none
module sbct_cell #(
    parameter int COORD_BITS     = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             up_valid,
    output logic                                                  up_ready,
    input  wire sbct_pkg::ctl_t                                   up_ctl,
    input  wire logic [sbct_pkg::NUM_LANES-1:0][COORD_BITS:0]     up_rem,
    input  wire logic [1:0][COORD_BITS-1:0]                       up_spd,
    input  wire logic [sbct_pkg::NUM_LANES-1:0][TIME_FRAC_BITS:0] up_q,
    input  wire logic                                             dn_ready,
    output logic                                                  dn_valid,
    output sbct_pkg::ctl_t                                        dn_ctl,
    output logic [sbct_pkg::NUM_LANES-1:0][COORD_BITS:0]          dn_rem,
    output logic [1:0][COORD_BITS-1:0]                            dn_spd,
    output logic [sbct_pkg::NUM_LANES-1:0][TIME_FRAC_BITS:0]      dn_q
);
    localparam int RW = COORD_BITS + 1;
    localparam int QW = TIME_FRAC_BITS + 1;

    logic                                     valid_reg, valid_next;
    sbct_pkg::ctl_t                           ctl_reg;
    logic [sbct_pkg::NUM_LANES-1:0][RW-1:0]   rem_reg, rem_next;
    logic [1:0][COORD_BITS-1:0]               spd_reg;
    logic [sbct_pkg::NUM_LANES-1:0][QW-1:0]   q_reg, q_next;

    always_comb
    begin
        logic [RW:0]   diff;
        logic          qbit;
        logic [RW-1:0] r;
        for (int l = 0; l < sbct_pkg::NUM_LANES; l++)
        begin
            diff = {1'b0, up_rem[l]} - {2'b00, up_spd[l >> 1]};
            qbit = !diff[RW];
            r    = qbit ? diff[RW-1:0] : up_rem[l];
            // remainder stays below the speed, so doubling fits
            rem_next[l] = {r[RW-2:0], 1'b0};
            q_next[l]   = {up_q[l][QW-2:0], qbit};
        end
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctl_reg <= up_ctl;
            rem_reg <= rem_next;
            spd_reg <= up_spd;
            q_reg   <= q_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_spd   = spd_reg;
    assign dn_q     = q_reg;
endmodule
`default_nettype wire

// ===== design/swept_box_contact_time.sv =====
// swept_box_contact_time: swept 2D box against box contact test, top level
// depends on sbct_pkg, sbct_front, sbct_cell
//
// usage: one transaction on the input channel carries two boxes (min and max
// corners, signed fixed point) and their displacements over one frame. each
// input transaction yields exactly one output transaction with hit and the
// first contact time as an unsigned fraction of the frame (1 << TIME_FRAC_BITS
// is the whole frame; 0 on a miss and for boxes that already touch).
// the path runs through one setup stage, TIME_FRAC_BITS + 1 divider cells that
// each settle one quotient bit of all four entry and exit times, and the
// output register.
// throughput is one transaction per cycle while the receiver does not stall.
// reset empties every stage; no output is valid after reset.
// when the receiver stalls, the output holds and bubbles inside the chain
// still close up, so the input keeps taking transactions until every stage
// is full.
`timescale 1ns / 1ps
`default_nettype none
module swept_box_contact_time #(
    parameter int COORD_BITS     = 24,
    parameter int TIME_FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_BITS-1:0]  a_min_x,
    input  wire logic signed [COORD_BITS-1:0]  a_min_y,
    input  wire logic signed [COORD_BITS-1:0]  a_max_x,
    input  wire logic signed [COORD_BITS-1:0]  a_max_y,
    input  wire logic signed [COORD_BITS-1:0]  b_min_x,
    input  wire logic signed [COORD_BITS-1:0]  b_min_y,
    input  wire logic signed [COORD_BITS-1:0]  b_max_x,
    input  wire logic signed [COORD_BITS-1:0]  b_max_y,
    input  wire logic signed [COORD_BITS-1:0]  vel_a_x,
    input  wire logic signed [COORD_BITS-1:0]  vel_a_y,
    input  wire logic signed [COORD_BITS-1:0]  vel_b_x,
    input  wire logic signed [COORD_BITS-1:0]  vel_b_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               hit,
    output logic [TIME_FRAC_BITS:0]            contact_time
);
    localparam int RW = COORD_BITS + 1;
    localparam int QW = TIME_FRAC_BITS + 1;
    localparam int NC = QW;
    localparam logic [QW-1:0] ONE = QW'(1) << TIME_FRAC_BITS;

    logic                                   st_valid [NC+1];
    logic                                   st_ready [NC+1];
    sbct_pkg::ctl_t                         st_ctl   [NC+1];
    logic [sbct_pkg::NUM_LANES-1:0][RW-1:0] st_rem   [NC+1];
    logic [1:0][COORD_BITS-1:0]             st_spd   [NC+1];
    logic [sbct_pkg::NUM_LANES-1:0][QW-1:0] st_q     [NC+1];

    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, hit_next;
    logic [QW-1:0]     time_reg, time_next;
    logic              last_ready;

    sbct_front #(
        .COORD_BITS     (COORD_BITS),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .a_min_x  (a_min_x),
        .a_min_y  (a_min_y),
        .a_max_x  (a_max_x),
        .a_max_y  (a_max_y),
        .b_min_x  (b_min_x),
        .b_min_y  (b_min_y),
        .b_max_x  (b_max_x),
        .b_max_y  (b_max_y),
        .vel_a_x  (vel_a_x),
        .vel_a_y  (vel_a_y),
        .vel_b_x  (vel_b_x),
        .vel_b_y  (vel_b_y),
        .dn_ready (st_ready[0]),
        .dn_valid (st_valid[0]),
        .dn_ctl   (st_ctl[0]),
        .dn_rem   (st_rem[0]),
        .dn_spd   (st_spd[0]),
        .dn_q     (st_q[0])
    );

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        sbct_cell #(
            .COORD_BITS     (COORD_BITS),
            .TIME_FRAC_BITS (TIME_FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[k]),
            .up_ready (st_ready[k]),
            .up_ctl   (st_ctl[k]),
            .up_rem   (st_rem[k]),
            .up_spd   (st_spd[k]),
            .up_q     (st_q[k]),
            .dn_ready (st_ready[k+1]),
            .dn_valid (st_valid[k+1]),
            .dn_ctl   (st_ctl[k+1]),
            .dn_rem   (st_rem[k+1]),
            .dn_spd   (st_spd[k+1]),
            .dn_q     (st_q[k+1])
        );
    end

    assign last_ready   = !out_valid_reg || !out_stall;
    assign st_ready[NC] = last_ready;

    // clamp each lane, then latest entry against earliest exit
    always_comb
    begin
        logic [QW-1:0] qc [sbct_pkg::NUM_LANES];
        logic [QW-1:0] first;
        logic [QW-1:0] last;
        sbct_pkg::ctl_t c;
        c = st_ctl[NC];
        for (int l = 0; l < sbct_pkg::NUM_LANES; l++)
        begin
            if (c.sat[l] || (st_q[NC][l][QW-1] && (st_q[NC][l][QW-2:0] != '0)))
                qc[l] = ONE;
            else
                qc[l] = st_q[NC][l];
        end
        first = '0;
        last  = ONE;
        if (c.en[0] && qc[0] > first) first = qc[0];
        if (c.en[2] && qc[2] > first) first = qc[2];
        if (c.en[1] && qc[1] < last)  last  = qc[1];
        if (c.en[3] && qc[3] < last)  last  = qc[3];
        if (c.early_hit)
        begin
            hit_next  = 1'b1;
            time_next = '0;
        end
        else if (!c.miss && (first <= last))
        begin
            hit_next  = 1'b1;
            time_next = first;
        end
        else
        begin
            hit_next  = 1'b0;
            time_next = '0;
        end
    end

    assign out_valid_next = last_ready ? st_valid[NC] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_ready && st_valid[NC])
        begin
            hit_reg  <= hit_next;
            time_reg <= time_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign contact_time = time_reg;
endmodule
`default_nettype wire

// ===== design/sbct_checker.sv =====
// sbct_checker: port level checks for swept_box_contact_time, bound to the top
// depends on swept_box_contact_time ports only
`timescale 1ns / 1ps
`default_nettype none
module sbct_checker #(
    parameter int TIME_FRAC_BITS = 16
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic                      hit,
    input wire logic [TIME_FRAC_BITS:0]   contact_time
);
    localparam logic [TIME_FRAC_BITS:0] ONE = (TIME_FRAC_BITS + 1)'(1) << TIME_FRAC_BITS;

    // a held transaction must stay valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // a held transaction must keep its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hit) && $stable(contact_time))
        else $error("output payload changed while stalled");

    // a miss reports zero time
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> contact_time == '0)
        else $error("miss with nonzero contact time");

    // contact time never beyond one frame
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> contact_time <= ONE)
        else $error("contact time above one frame");
endmodule

bind swept_box_contact_time sbct_checker #(
    .TIME_FRAC_BITS (TIME_FRAC_BITS)
) u_sbct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .contact_time (contact_time)
);
`default_nettype wire
